### design/ctft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctft_pkg
// Shared types and constants of the change-triggered frame throttle: register
// indexes, verdict codes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package ctft_pkg;

    // Field widths of one frame.
    localparam int ID_W      = 11;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int TIME_W    = 32;
    localparam int GAP_W     = 16;
    localparam int BYTES     = PAYLOAD_W / 8;

    // Number of slots that have configuration registers.
    localparam int REG_SLOTS = 2;

    // Default number of slots with state storage.
    localparam int NUM_SLOTS_DEF = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SLOTS_W    = 2;

    // Register reset values.
    localparam logic [GAP_W-1:0] MIN_GAP_RST   = 16'd5;
    localparam logic [GAP_W-1:0] HEARTBEAT_RST = 16'd20;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOTS_IN_USE   = 3'd0,
        REG_SLOT0_ID       = 3'd1,
        REG_SLOT1_ID       = 3'd2,
        REG_SLOT0_MIN_GAP  = 3'd3,
        REG_SLOT0_HEARTBT  = 3'd4,
        REG_SLOT1_MIN_GAP  = 3'd5,
        REG_SLOT1_HEARTBT  = 3'd6
    } cfg_index_t;

    // Verdict codes of one result.
    typedef enum logic [1:0] {
        VERDICT_SUPPRESSED = 2'd0,
        VERDICT_CHANGED    = 2'd1,
        VERDICT_HEARTBEAT  = 2'd2,
        VERDICT_UNKNOWN_ID = 2'd3
    } verdict_t;

    // Configuration bundle handed from the register file to the slot table.
    typedef struct packed {
        logic [SLOTS_W-1:0]                 slots_in_use;
        logic [REG_SLOTS-1:0][ID_W-1:0]     slot_id;
        logic [REG_SLOTS-1:0][GAP_W-1:0]    min_gap_ms;
        logic [REG_SLOTS-1:0][GAP_W-1:0]    heartbeat_ms;
    } cfg_t;

    // One offered frame as held in the input register.
    typedef struct packed {
        logic [ID_W-1:0]      frame_id;
        logic [LEN_W-1:0]     frame_len;
        logic [PAYLOAD_W-1:0] frame_payload;
        logic [TIME_W-1:0]    now_ms;
    } frame_t;

    // Decision for one frame, before the result register.
    typedef struct packed {
        verdict_t             verdict;
        logic [ID_W-1:0]      out_id;
        logic [LEN_W-1:0]     out_len;
        logic [PAYLOAD_W-1:0] out_payload;
    } result_t;

endpackage

### design/ctft_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctft_frame_if
// Valid/ready channel that carries one offered CAN frame per transfer.
// ----------------------------------------------------------------------------
interface ctft_frame_if;
    logic                           valid;
    logic                           ready;
    logic [ctft_pkg::ID_W-1:0]      frame_id;
    logic [ctft_pkg::LEN_W-1:0]     frame_len;
    logic [ctft_pkg::PAYLOAD_W-1:0] frame_payload;
    logic [ctft_pkg::TIME_W-1:0]    now_ms;

    modport source (
        output valid, frame_id, frame_len, frame_payload, now_ms,
        input  ready
    );

    modport sink (
        input  valid, frame_id, frame_len, frame_payload, now_ms,
        output ready
    );
endinterface

### design/ctft_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctft_result_if
// Valid/ready channel that carries one throttle result per transfer.
// ----------------------------------------------------------------------------
interface ctft_result_if;
    logic                           valid;
    logic                           ready;
    ctft_pkg::verdict_t             verdict;
    logic [ctft_pkg::ID_W-1:0]      out_id;
    logic [ctft_pkg::LEN_W-1:0]     out_len;
    logic [ctft_pkg::PAYLOAD_W-1:0] out_payload;

    modport source (
        output valid, verdict, out_id, out_len, out_payload,
        input  ready
    );

    modport sink (
        input  valid, verdict, out_id, out_len, out_payload,
        output ready
    );
endinterface

### design/change_triggered_frame_throttle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// change_triggered_frame_throttle
// A frame passes through the input register, then the result register, which
// takes the decision once the result side is free; the slot match, masked
// payload compare and elapsed-time check sit between the two.
// Throughput: one frame per cycle while the result side keeps taking results.
// Reset returns the configuration registers to their defaults and clears all slot state to zero.
// ----------------------------------------------------------------------------
module change_triggered_frame_throttle #(
    parameter int NUM_SLOTS = ctft_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ctft_frame_if.sink                      frame,
    ctft_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [ctft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctft_pkg::CFG_DATA_W-1:0] cfg_data
);

    ctft_pkg::cfg_t    cfg;
    ctft_pkg::frame_t  in_reg;
    ctft_pkg::result_t decision;
    ctft_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              advance;

    // Pipeline control: the result register frees up when its result is taken.
    assign out_free    = !out_valid_reg || result.ready;
    assign advance     = in_valid_reg && out_free;
    assign frame.ready = !in_valid_reg || out_free;

    ctft_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctft_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .frame  (in_reg),
        .commit (advance),
        .result (decision)
    );

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame.ready)
            begin
                in_valid_reg <= frame.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input register takes a frame on each transfer.
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_reg.frame_id      <= frame.frame_id;
            in_reg.frame_len     <= frame.frame_len;
            in_reg.frame_payload <= frame.frame_payload;
            in_reg.now_ms        <= frame.now_ms;
        end
    end

    // Result register takes the decision when the stage advances.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= decision;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.verdict     = out_reg.verdict;
    assign result.out_id      = out_reg.out_id;
    assign result.out_len     = out_reg.out_len;
    assign result.out_payload = out_reg.out_payload;

endmodule

### design/ctft_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctft_cfg_regs
// Configuration register file: slot count, slot identifiers and the two gaps
// of each slot, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ctft_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ctft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctft_pkg::CFG_DATA_W-1:0] cfg_data,
    output ctft_pkg::cfg_t                  cfg
);

    ctft_pkg::cfg_t cfg_reg;
    ctft_pkg::cfg_t cfg_next;

    // Decode one register write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ctft_pkg::cfg_index_t'(cfg_index))
                ctft_pkg::REG_SLOTS_IN_USE:
                    cfg_next.slots_in_use = cfg_data[ctft_pkg::SLOTS_W-1:0];
                ctft_pkg::REG_SLOT0_ID:
                    cfg_next.slot_id[0] = cfg_data[ctft_pkg::ID_W-1:0];
                ctft_pkg::REG_SLOT1_ID:
                    cfg_next.slot_id[1] = cfg_data[ctft_pkg::ID_W-1:0];
                ctft_pkg::REG_SLOT0_MIN_GAP:
                    cfg_next.min_gap_ms[0] = cfg_data[ctft_pkg::GAP_W-1:0];
                ctft_pkg::REG_SLOT0_HEARTBT:
                    cfg_next.heartbeat_ms[0] = cfg_data[ctft_pkg::GAP_W-1:0];
                ctft_pkg::REG_SLOT1_MIN_GAP:
                    cfg_next.min_gap_ms[1] = cfg_data[ctft_pkg::GAP_W-1:0];
                ctft_pkg::REG_SLOT1_HEARTBT:
                    cfg_next.heartbeat_ms[1] = cfg_data[ctft_pkg::GAP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slots_in_use <= '0;
            for (int i = 0; i < ctft_pkg::REG_SLOTS; i++)
            begin
                cfg_reg.slot_id[i]      <= '0;
                cfg_reg.min_gap_ms[i]   <= ctft_pkg::MIN_GAP_RST;
                cfg_reg.heartbeat_ms[i] <= ctft_pkg::HEARTBEAT_RST;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/ctft_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctft_slot_table
// Per-slot state (last offered payload, last send time), identifier match,
// change detection and gap check. The state of the matched slot is updated
// when the decision is committed to the result register.
// ----------------------------------------------------------------------------
module ctft_slot_table #(
    parameter int NUM_SLOTS = ctft_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctft_pkg::cfg_t    cfg,
    input  ctft_pkg::frame_t  frame,
    input  logic              commit,
    output ctft_pkg::result_t result
);

    logic [NUM_SLOTS-1:0][ctft_pkg::PAYLOAD_W-1:0] last_payload_reg;
    logic [NUM_SLOTS-1:0][ctft_pkg::TIME_W-1:0]    last_send_reg;

    logic [NUM_SLOTS-1:0]            hit;
    logic                            found;
    logic [ctft_pkg::PAYLOAD_W-1:0]  sel_payload;
    logic [ctft_pkg::TIME_W-1:0]     sel_send;
    logic [ctft_pkg::GAP_W-1:0]      sel_min_gap;
    logic [ctft_pkg::GAP_W-1:0]      sel_heartbeat;
    logic [ctft_pkg::LEN_W-1:0]      len_c;
    logic [ctft_pkg::PAYLOAD_W-1:0]  mask;
    logic                            same;
    logic [ctft_pkg::TIME_W-1:0]     elapsed;
    logic                            send;

    // First matching enabled slot wins; slots past the slot count are off.
    always_comb
    begin
        found         = 1'b0;
        hit           = '0;
        sel_payload   = '0;
        sel_send      = '0;
        sel_min_gap   = '0;
        sel_heartbeat = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!found && (ctft_pkg::SLOTS_W'(i) < cfg.slots_in_use)
                && (cfg.slot_id[i] == frame.frame_id))
            begin
                found         = 1'b1;
                hit[i]        = 1'b1;
                sel_payload   = last_payload_reg[i];
                sel_send      = last_send_reg[i];
                sel_min_gap   = cfg.min_gap_ms[i];
                sel_heartbeat = cfg.heartbeat_ms[i];
            end
        end
    end

    // Length above eight bytes counts as eight; one mask byte per valid byte.
    always_comb
    begin
        len_c = (frame.frame_len > ctft_pkg::LEN_W'(ctft_pkg::BYTES))
              ? ctft_pkg::LEN_W'(ctft_pkg::BYTES) : frame.frame_len;
        for (int b = 0; b < ctft_pkg::BYTES; b++)
        begin
            mask[b*8 +: 8] = {8{ctft_pkg::LEN_W'(b) < len_c}};
        end
    end

    // Change detection and gap check with modular elapsed time.
    always_comb
    begin
        same    = ((frame.frame_payload ^ sel_payload) & mask) == '0;
        elapsed = frame.now_ms - sel_send;
        if (same)
        begin
            send = elapsed >= ctft_pkg::TIME_W'(sel_heartbeat);
        end
        else
        begin
            send = elapsed >= ctft_pkg::TIME_W'(sel_min_gap);
        end
    end

    // Result fields; a frame that is not sent shows zero id, length and payload.
    always_comb
    begin
        result = '0;
        if (!found)
        begin
            result.verdict = ctft_pkg::VERDICT_UNKNOWN_ID;
        end
        else if (send)
        begin
            result.verdict     = same ? ctft_pkg::VERDICT_HEARTBEAT
                                      : ctft_pkg::VERDICT_CHANGED;
            result.out_id      = frame.frame_id;
            result.out_len     = len_c;
            result.out_payload = frame.frame_payload & mask;
        end
        else
        begin
            result.verdict = ctft_pkg::VERDICT_SUPPRESSED;
        end
    end

    // Slot state: payload always stored on a match, send time only on a send.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_payload_reg <= '0;
            last_send_reg    <= '0;
        end
        else if (commit)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (hit[i])
                begin
                    last_payload_reg[i] <= frame.frame_payload;
                    if (send)
                    begin
                        last_send_reg[i] <= frame.now_ms;
                    end
                end
            end
        end
    end

endmodule
